// ===== rtl/assert_macros.svh =====
// assertion helper macros for the heading lock rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define VHL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define VHL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/vhl_pkg.sv =====
// shared types, constants and arctangent table for the heading lock block
// no dependencies
package vhl_pkg;

    localparam int VEL_W            = 16;
    localparam int CFG_W            = 15;
    localparam int HEAD_W           = 16;
    localparam int XY_W             = 27;
    localparam int ACC_W            = 32;
    localparam int TABLE_LEN        = 24;
    localparam int DEF_CORDIC_STEPS = 16;

    // accumulator scale: 2^31 stands for pi
    localparam logic [ACC_W-1:0] ACC_PLUS_HALF_PI  = 32'h4000_0000;
    localparam logic [ACC_W-1:0] ACC_MINUS_HALF_PI = 32'hC000_0000;
    localparam logic [ACC_W-1:0] ACC_ROUND         = 32'h0000_8000;

    // atan(2^-i) in accumulator units
    localparam logic [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ANGLE_RATE  = 2'd0,
        CFG_LOCK_MARGIN = 2'd1,
        CFG_SPEED       = 2'd2
    } t_cfg_reg;

    // one vector on its way through the cordic stages
    typedef struct packed {
        logic                    lock;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic        [ACC_W-1:0] acc;
    } t_cordic_state;

endpackage

// ===== rtl/vhl_cordic_pipe.sv =====
// vectoring cordic, one iteration per pipeline stage, with elastic valid/ready flow
// depends on vhl_pkg and assert_macros.svh
`include "assert_macros.svh"

module vhl_cordic_pipe #(
    parameter int NSTEP = vhl_pkg::DEF_CORDIC_STEPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  vhl_pkg::t_cordic_state i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output vhl_pkg::t_cordic_state o_data
);
    import vhl_pkg::*;

    t_cordic_state r_st   [NSTEP];
    logic          r_vld  [NSTEP];
    t_cordic_state src_st [NSTEP+1];
    logic          src_vld[NSTEP+1];
    logic          en     [NSTEP+1];

    // stage sources: the pipe input, then each stage register
    assign src_st[0]  = i_data;
    assign src_vld[0] = i_valid;
    assign en[NSTEP]  = i_ready;

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        t_cordic_state          n_st;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;

        assign src_st[k+1]  = r_st[k];
        assign src_vld[k+1] = r_vld[k];

        // a stage loads when empty or when its contents move on
        assign en[k] = !r_vld[k] || en[k+1];

        // one rotation toward the x axis
        always_comb begin
            dx   = src_st[k].y >>> k;
            dy   = src_st[k].x >>> k;
            n_st = src_st[k];
            if (!src_st[k].y[XY_W-1]) begin
                n_st.x   = src_st[k].x + dx;
                n_st.y   = src_st[k].y - dy;
                n_st.acc = src_st[k].acc + ATAN_TAB[k];
            end else begin
                n_st.x   = src_st[k].x - dx;
                n_st.y   = src_st[k].y + dy;
                n_st.acc = src_st[k].acc - ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= src_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NSTEP-1];
    assign o_data  = r_st[NSTEP-1];

    // a held last stage keeps its transaction
    `VHL_ASSERT_NEXT(a_last_stage_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

endmodule

// ===== rtl/velocity_heading_lock.sv =====
// velocity heading lock: top level with config registers, lock decision and output stage
// depends on vhl_pkg, vhl_cordic_pipe and assert_macros.svh
//
// Takes one velocity transaction per clock while o_in_ready is high and returns one result
// per transaction, in order. A result passes through the input register, which loads at
// the edge that accepts its input, then a squaring stage, one stage per CORDIC iteration
// and the output register before it appears on o_out_valid; that depth is set by the unrolled
// CORDIC, one iteration per stage. Every stage is elastic, so a stalled output fills the
// pipeline before o_in_ready drops.
// CORDIC_STEPS above 24 is limited to 24. Configuration writes are taken at any time
// (o_cfg_ready is always high) and should be made while no transaction is in flight.
`include "assert_macros.svh"

module velocity_heading_lock #(
    parameter int CORDIC_STEPS = vhl_pkg::DEF_CORDIC_STEPS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [vhl_pkg::VEL_W-1:0]  i_vel_x,
    input  logic signed [vhl_pkg::VEL_W-1:0]  i_vel_y,
    input  logic signed [vhl_pkg::VEL_W-1:0]  i_yaw_rate,
    // configuration channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [vhl_pkg::CFG_W-1:0]   i_cfg_data,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_locked,
    output logic signed [vhl_pkg::HEAD_W-1:0] o_heading
);
    import vhl_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    // configuration registers
    logic [CFG_W-1:0] r_thr_rate;
    logic [CFG_W-1:0] r_margin;
    logic [CFG_W-1:0] r_thr_speed;

    // lock history and held heading
    logic              r_prev_locked;
    logic [HEAD_W-1:0] r_held;

    // input stage
    logic                    r_s0_vld;
    logic signed [VEL_W-1:0] r_s0_vx;
    logic signed [VEL_W-1:0] r_s0_vy;
    logic signed [VEL_W-1:0] r_s0_wz;

    // squaring stage
    logic                    r_s1_vld;
    logic signed [VEL_W-1:0] r_s1_vx;
    logic signed [VEL_W-1:0] r_s1_vy;
    logic [30:0]             r_s1_sqx;
    logic [30:0]             r_s1_sqy;
    logic [29:0]             r_s1_st2;
    logic                    r_s1_ltb;
    logic                    r_s1_ltw;

    // output stage
    logic              r_out_vld;
    logic              r_out_locked;
    logic [HEAD_W-1:0] r_out_heading;

    logic en_s0, en_s1, en_out;
    logic s1_fire;

    logic signed [31:0]  prod_x;
    logic signed [31:0]  prod_y;
    logic [29:0]         st2;
    logic [VEL_W-1:0]    absz;
    logic [VEL_W-1:0]    wide_lim;

    logic [31:0]         mag2;
    logic                lim_ok;
    logic                spd_ok;
    logic                lock;
    logic signed [XY_W-1:0] x0, y0;
    t_cordic_state       pipe_in;
    t_cordic_state       pipe_out;
    logic                pipe_ready;
    logic                pipe_vld;
    logic [ACC_W-1:0]    rnd;
    logic [HEAD_W-1:0]   n_heading;

    // configuration writes; unknown index is ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_rate  <= '0;
            r_margin    <= '0;
            r_thr_speed <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_ANGLE_RATE:  r_thr_rate  <= i_cfg_data;
                CFG_LOCK_MARGIN: r_margin    <= i_cfg_data;
                CFG_SPEED:       r_thr_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables, back from the output register
    assign en_out     = !r_out_vld || i_out_ready;
    assign en_s1      = !r_s1_vld || pipe_ready;
    assign en_s0      = !r_s0_vld || en_s1;
    assign o_in_ready = en_s0;
    assign s1_fire    = r_s1_vld && pipe_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en_s0) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s0) begin
            r_s0_vx <= i_vel_x;
            r_s0_vy <= i_vel_y;
            r_s0_wz <= i_yaw_rate;
        end
    end

    // squares and the two rate compares
    assign prod_x   = 32'(r_s0_vx) * 32'(r_s0_vx);
    assign prod_y   = 32'(r_s0_vy) * 32'(r_s0_vy);
    assign st2      = 30'(r_thr_speed) * 30'(r_thr_speed);
    assign absz     = r_s0_wz[VEL_W-1] ? VEL_W'(-r_s0_wz) : VEL_W'(r_s0_wz);
    assign wide_lim = {1'b0, r_thr_rate} + {1'b0, r_margin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en_s1) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_vx  <= r_s0_vx;
            r_s1_vy  <= r_s0_vy;
            r_s1_sqx <= prod_x[30:0];
            r_s1_sqy <= prod_y[30:0];
            r_s1_st2 <= st2;
            r_s1_ltb <= absz < {1'b0, r_thr_rate};
            r_s1_ltw <= absz < wide_lim;
        end
    end

    // lock decision with hysteresis from the previous transaction
    assign mag2   = {1'b0, r_s1_sqx} + {1'b0, r_s1_sqy};
    assign spd_ok = mag2 > {2'b00, r_s1_st2};
    assign lim_ok = r_prev_locked ? r_s1_ltw : r_s1_ltb;
    assign lock   = lim_ok && spd_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_locked <= 1'b0;
        end else if (s1_fire) begin
            r_prev_locked <= lock;
        end
    end

    // scale by 256 and turn left half plane vectors by a quarter turn
    assign x0 = {{(XY_W-VEL_W-8){r_s1_vx[VEL_W-1]}}, r_s1_vx, 8'h00};
    assign y0 = {{(XY_W-VEL_W-8){r_s1_vy[VEL_W-1]}}, r_s1_vy, 8'h00};

    always_comb begin
        pipe_in.lock = lock;
        pipe_in.x    = x0;
        pipe_in.y    = y0;
        pipe_in.acc  = '0;
        if (r_s1_vx[VEL_W-1]) begin
            if (!r_s1_vy[VEL_W-1]) begin
                pipe_in.x   = y0;
                pipe_in.y   = -x0;
                pipe_in.acc = ACC_PLUS_HALF_PI;
            end else begin
                pipe_in.x   = -y0;
                pipe_in.y   = x0;
                pipe_in.acc = ACC_MINUS_HALF_PI;
            end
        end
    end

    vhl_cordic_pipe #(
        .NSTEP (NSTEP)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_vld),
        .o_ready (pipe_ready),
        .i_data  (pipe_in),
        .o_valid (pipe_vld),
        .i_ready (en_out),
        .o_data  (pipe_out)
    );

    // round the angle to 16 bits, hold the last locked heading
    assign rnd       = pipe_out.acc + ACC_ROUND;
    assign n_heading = pipe_out.lock ? rnd[ACC_W-1:ACC_W-HEAD_W] : r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_held    <= '0;
        end else begin
            if (en_out) begin
                r_out_vld <= pipe_vld;
            end
            if (en_out && pipe_vld) begin
                r_held <= n_heading;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out && pipe_vld) begin
            r_out_locked  <= pipe_out.lock;
            r_out_heading <= n_heading;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_locked    = r_out_locked;
    assign o_heading   = r_out_heading;

    // the shown result always carries the held heading
    `VHL_ASSERT_NOW(a_out_matches_held, i_clk, i_rst_n, r_out_vld, r_out_heading == r_held)
    // lock history follows each transaction leaving the decision stage
    `VHL_ASSERT_NEXT(a_prev_tracks_lock, i_clk, i_rst_n, s1_fire, r_prev_locked == $past(lock))
    // input backpressure only when both front stages are full
    `VHL_ASSERT_NOW(a_ready_when_room, i_clk, i_rst_n, !o_in_ready, r_s0_vld && r_s1_vld)
    // a zero rate limit locks only through the margin while the previous transaction was locked
    `VHL_ASSERT_NOW(a_zero_limit_no_lock, i_clk, i_rst_n, s1_fire && lock, (r_thr_rate != '0) || (r_prev_locked && (r_margin != '0)))

endmodule
